### rtl/core/ssq_pkg.sv
// Shared constants, operation codes and cell control type for the sorted set core.
`default_nettype none

package ssq_pkg;

  // Set geometry.
  localparam int unsigned CAPACITY    = 64;
  localparam int unsigned VALUE_WIDTH = 24;
  localparam int unsigned COUNT_W     = $clog2(CAPACITY + 1);

  // Beat field widths.
  localparam int unsigned OP_W           = 2;
  localparam int unsigned ITEM_W         = 24;
  localparam int unsigned MCOUNT_W       = 7;
  localparam int unsigned IN_FIELDS_W    = OP_W + ITEM_W;
  localparam int unsigned OUT_FIELDS_W   = 1 + MCOUNT_W + 1;
  localparam int unsigned IN_TDATA_W     = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Operation codes; the unused code behaves as a query.
  localparam logic [OP_W-1:0] OP_TOGGLE = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // Broadcast from the controller to every cell of the row.
  typedef struct packed {
    logic                   cmp;    // capture compare flags against value
    logic                   ins;    // open a slot at the insert point
    logic                   rem;    // close the slot at the matching entry
    logic [VALUE_WIDTH-1:0] value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/core/sorted_set_toggle_and_query_core.sv
// Top level of the sorted set core: stream handshake, sequencing and the row of cells.
`default_nettype none

// Channel   Dir  Signals                     Beat contents (lowest bit first)
// s_axis    in   tvalid/tready/tdata[31:0]   operation[1:0], item_value[25:2]
// m_axis    out  tvalid/tready/tdata[15:0]   was_member[0], member_count[7:1], rejected[8]
//
// Every item passes through the accept cycle, a compare cycle in which each cell
// checks its entry against the value, and an update cycle in which the row shifts and
// the result is written to the output register; a new beat is accepted in the next cycle.
// The update cycle waits while the output register still holds an untaken result.
// Reset clears the member count and control state only; entries need no clearing pass
// because cells at or past the count are never read.

module sorted_set_toggle_and_query_core (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // operation[1:0], item_value[25:2], zero pad above
  input  wire  [ssq_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  input  wire                                s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // was_member[0], member_count[7:1], rejected[8], zero pad above
  output logic [ssq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  output logic                               m_axis_tvalid_o,
  input  wire                                m_axis_tready_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  localparam int unsigned NCELL = ssq_pkg::CAPACITY;
  localparam int unsigned VW    = ssq_pkg::VALUE_WIDTH;
  localparam int unsigned CW    = ssq_pkg::COUNT_W;

  logic [1:0]                  state_q, state_d;
  logic [ssq_pkg::OP_W-1:0]    op_q;
  logic [VW-1:0]               value_q;
  logic [CW-1:0]               count_q, count_d;
  logic                        out_valid_q, out_valid_d;
  logic [ssq_pkg::OUT_TDATA_W-1:0] out_data_q, out_data_d;

  logic                        in_fire, upd_fire;
  logic                        is_toggle, is_clear, was_any, full;
  logic                        res_was, res_rej;
  logic [CW-1:0]               res_count;
  ssq_pkg::cell_ctrl_t         ctrl;

  logic [VW-1:0]               entry [NCELL];
  logic [NCELL-1:0]            lt_vec;
  logic [NCELL-1:0]            eq_vec;

  // The core takes a new beat only between items.
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign upd_fire        = (state_q == ST_UPD) && (!out_valid_q || m_axis_tready_i);

  assign is_toggle = (op_q == ssq_pkg::OP_TOGGLE);
  assign is_clear  = (op_q == ssq_pkg::OP_CLEAR);
  assign was_any   = |eq_vec;
  assign full      = (count_q == CW'(ssq_pkg::CAPACITY));

  // A clear reports no membership; a query (and the unused code) changes nothing.
  assign res_was = !is_clear && was_any;
  assign res_rej = is_toggle && !was_any && full;

  always_comb begin
    ctrl.cmp   = (state_q == ST_CMP);
    ctrl.ins   = upd_fire && is_toggle && !was_any && !full;
    ctrl.rem   = upd_fire && is_toggle && was_any;
    ctrl.value = value_q;
  end

  always_comb begin
    count_d = count_q;
    if (upd_fire) begin
      if (is_clear) begin
        count_d = '0;
      end else if (ctrl.ins) begin
        count_d = count_q + CW'(1);
      end else if (ctrl.rem) begin
        count_d = count_q - CW'(1);
      end
    end
  end

  assign res_count = count_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (upd_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register: loaded in the update cycle, held until the sink takes it.
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (upd_fire) begin
      out_valid_d = 1'b1;
      out_data_d  = ssq_pkg::OUT_TDATA_W'({res_rej,
                                           ssq_pkg::MCOUNT_W'(res_count),
                                           res_was});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q    <= s_axis_tdata_i[ssq_pkg::OP_W-1:0];
      value_q <= VW'(s_axis_tdata_i[ssq_pkg::IN_FIELDS_W-1:ssq_pkg::OP_W]);
    end
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Row of cells. The first cell sees a left neighbor that is always below the value,
  // so it loads the new value on insert; the last cell refills from itself on removal.
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    logic [VW-1:0] left_entry, right_entry;
    logic          left_lt, occ;

    if (i == 0) begin : g_first
      assign left_entry = value_q;
      assign left_lt    = 1'b1;
    end else begin : g_mid
      assign left_entry = entry[i-1];
      assign left_lt    = lt_vec[i-1];
    end

    if (i == NCELL - 1) begin : g_last
      assign right_entry = entry[i];
    end else begin : g_inner
      assign right_entry = entry[i+1];
    end

    assign occ = (CW'(i) < count_q);

    ssq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .occ_i         (occ),
      .left_entry_i  (left_entry),
      .left_lt_i     (left_lt),
      .right_entry_i (right_entry),
      .entry_o       (entry[i]),
      .lt_o          (lt_vec[i]),
      .eq_o          (eq_vec[i])
    );
  end

`ifndef SYNTHESIS
  // The count never passes the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(ssq_pkg::CAPACITY))
    else $error("member count above capacity");

  // Stored entries are strictly ascending, so at most one cell can match.
  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) |-> $onehot0(eq_vec))
    else $error("more than one cell matches the value");

  // A refused insert is only reported with a full set.
  a_reject_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_fire && res_rej) |->
      (ssq_pkg::MCOUNT_W'(res_count) == ssq_pkg::MCOUNT_W'(ssq_pkg::CAPACITY)))
    else $error("rejected insert with free space");

  // Every update leaves a result waiting at the output.
  a_result_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_fire |=> m_axis_tvalid_o)
    else $error("update produced no result beat");
`endif

endmodule

`default_nettype wire

### rtl/core/ssq_cell.sv
// One storage cell of the sorted row: holds an entry, compares it and shifts with its neighbors.
`default_nettype none

module ssq_cell (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire  ssq_pkg::cell_ctrl_t           ctrl_i,
  input  wire                                 occ_i,
  input  wire  [ssq_pkg::VALUE_WIDTH-1:0]     left_entry_i,
  input  wire                                 left_lt_i,
  input  wire  [ssq_pkg::VALUE_WIDTH-1:0]     right_entry_i,
  output logic [ssq_pkg::VALUE_WIDTH-1:0]     entry_o,
  output logic                                lt_o,
  output logic                                eq_o
);

  logic [ssq_pkg::VALUE_WIDTH-1:0] entry_q, entry_d;
  logic                            lt_q, eq_q;

  // Flags are only meaningful for occupied cells; free cells read as not below.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
      eq_q <= 1'b0;
    end else if (ctrl_i.cmp) begin
      lt_q <= occ_i && (entry_q < ctrl_i.value);
      eq_q <= occ_i && (entry_q == ctrl_i.value);
    end
  end

  // Cells at or past the insert point take their left neighbor, the first one takes
  // the new value; on removal cells at or past the match take their right neighbor.
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins && !lt_q) begin
      entry_d = left_lt_i ? ctrl_i.value : left_entry_i;
    end else if (ctrl_i.rem && !lt_q) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign lt_o    = lt_q;
  assign eq_o    = eq_q;

endmodule

`default_nettype wire

### tb/sorted_set_toggle_and_query_core_test.sv
// Self-checking testbench for the sorted set core: directed and random toggle, query and clear beats.
`timescale 1ns / 1ps

module sorted_set_toggle_and_query_core_test;
  import ssq_pkg::*;

  // The fourth operation code has no name in the package; the core treats it as a query.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 8;

  // Field layout of one result beat, lowest bit last in the declaration.
  typedef struct packed {
    logic                rejected;
    logic [MCOUNT_W-1:0] member_count;
    logic                was_member;
  } set_result_t;

  // Mirror of the set contents plus the queue of results still owed by the core.
  class set_scoreboard;
    logic [ITEM_W-1:0] members[$];  // strictly ascending
    set_result_t       owed_q[$];
    int unsigned       errors;
    int unsigned       checked;
    int unsigned       n_inserts, n_removes, n_rejects, n_queries, n_clears;
    int unsigned       peak_count;

    function void note_input(logic [OP_W-1:0] op, logic [ITEM_W-1:0] value);
      set_result_t res;
      int          pos;
      res = '0;
      if (op == OP_CLEAR) begin
        members.delete();
        n_clears++;
      end else begin
        pos = 0;
        while (pos < members.size() && members[pos] < value) pos++;
        res.was_member = (pos < members.size()) && (members[pos] == value);
        if (op == OP_TOGGLE) begin
          if (res.was_member) begin
            members.delete(pos);
            n_removes++;
          end else if (members.size() >= CAPACITY) begin
            res.rejected = 1'b1;
            n_rejects++;
          end else begin
            members.insert(pos, value);
            n_inserts++;
          end
        end else begin
          n_queries++;
        end
      end
      res.member_count = MCOUNT_W'(members.size());
      if (members.size() > peak_count) peak_count = members.size();
      owed_q.push_back(res);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] beat);
      set_result_t got;
      set_result_t want;
      got = set_result_t'(beat[OUT_FIELDS_W-1:0]);
      if (owed_q.size() == 0) begin
        $error("result beat 0x%0h arrived with no item outstanding", beat);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      checked++;
      if (got.was_member !== want.was_member) begin
        $error("was_member: expected %0d, got %0d", want.was_member, got.was_member);
        errors++;
      end
      if (got.member_count !== want.member_count) begin
        $error("member_count: expected %0d, got %0d", want.member_count, got.member_count);
        errors++;
      end
      if (got.rejected !== want.rejected) begin
        $error("rejected: expected %0d, got %0d", want.rejected, got.rejected);
        errors++;
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i = '0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;

  int unsigned    send_idle_pct = 0;
  int unsigned    recv_stall_pct = 0;
  int unsigned    cycle_count = 0;
  set_scoreboard  sb = new();

  sorted_set_toggle_and_query_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Result side: take beats when ready was high at the edge, then choose the next ready.
  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      sb.check_result(m_axis_tdata_o);
    end
    m_axis_tready_i <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.owed_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  // Valid is only lowered when an idle gap follows, so it never drops and rises in one step.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [ITEM_W-1:0] value);
    int unsigned gap;
    gap = 0;
    while (gap < 64 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata_i  <= IN_TDATA_W'({value, op});
    s_axis_tvalid_i <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_input(op, value);
  endtask

  // Mostly values that hit the set or sit right beside a stored value.
  function automatic logic [ITEM_W-1:0] pick_value();
    int unsigned roll;
    logic [ITEM_W-1:0] base;
    roll = $urandom_range(99);
    if (sb.members.size() == 0 || roll < 30) return ITEM_W'($urandom);
    base = sb.members[$urandom_range(sb.members.size() - 1)];
    if (roll < 75) return base;
    return (roll < 88) ? base + ITEM_W'(1) : base - ITEM_W'(1);
  endfunction

  // Fill to capacity, push against the limit, then open and refill one slot.
  task automatic fill_and_overflow();
    send_item(OP_CLEAR, ITEM_W'($urandom));
    while (sb.members.size() < CAPACITY) begin
      send_item(OP_TOGGLE, ($urandom_range(9) == 0) ? pick_value() : ITEM_W'($urandom));
    end
    repeat (3) send_item(OP_TOGGLE, ITEM_W'($urandom));
    repeat (4) send_item(OP_QUERY, pick_value());
    send_item(OP_TOGGLE, sb.members[$urandom_range(CAPACITY - 1)]);
    send_item(OP_TOGGLE, ITEM_W'($urandom));
    send_item(OP_TOGGLE, ITEM_W'($urandom));
    send_item(OP_UNUSED, pick_value());
  endtask

  task automatic churn(input int unsigned n);
    int unsigned roll;
    repeat (n) begin
      roll = $urandom_range(99);
      if (roll < 52) send_item(OP_TOGGLE, pick_value());
      else if (roll < 90) send_item(OP_QUERY, pick_value());
      else if (roll < 95) send_item(OP_UNUSED, pick_value());
      else send_item(OP_CLEAR, ITEM_W'($urandom));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: value extremes, every operation code, removal from the middle, clears.
    send_item(OP_QUERY,  24'h000000);
    send_item(OP_TOGGLE, 24'h000000);
    send_item(OP_TOGGLE, 24'hFFFFFF);
    send_item(OP_QUERY,  24'h000000);
    send_item(OP_QUERY,  24'hFFFFFF);
    send_item(OP_QUERY,  24'h000001);
    send_item(OP_UNUSED, 24'hFFFFFF);
    send_item(OP_TOGGLE, 24'h800000);
    send_item(OP_TOGGLE, 24'h7FFFFF);
    send_item(OP_TOGGLE, 24'h555555);
    send_item(OP_TOGGLE, 24'h800000);
    send_item(OP_QUERY,  24'h800000);
    send_item(OP_TOGGLE, 24'h000000);
    send_item(OP_QUERY,  24'h7FFFFF);
    send_item(OP_CLEAR,  24'hAAAAAA);
    send_item(OP_QUERY,  24'hFFFFFF);
    send_item(OP_CLEAR,  24'h000000);
    send_item(OP_TOGGLE, 24'hFFFFFF);
    send_item(OP_TOGGLE, 24'hFFFFFF);

    // Random: no idling, sender idle, receiver stalling, then both.
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 76 : (phase == 3) ? 16 : 0;
      recv_stall_pct = (phase == 2) ? 76 : (phase == 3) ? 16 : 0;
      fill_and_overflow();
      churn(60);
    end

    @(posedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("checked %0d results: %0d inserts, %0d removes, %0d refused inserts into a full set",
             sb.checked, sb.n_inserts, sb.n_removes, sb.n_rejects);
    $display("also %0d queries and %0d clears; largest set held %0d values",
             sb.n_queries, sb.n_clears, sb.peak_count);
    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/ssq_pkg.sv
rtl/core/ssq_cell.sv
rtl/core/sorted_set_toggle_and_query_core.sv
tb/sorted_set_toggle_and_query_core_test.sv
